/* design/tea_pkg.sv */
// tea_pkg: shared types, constants and the half-round mix function for the
// tea block cipher unit. No dependencies.
package tea_pkg;

   localparam int unsigned WORD_W    = 32;
   localparam int unsigned KEY_COUNT = 4;
   localparam int unsigned KEY_IDX_W = 2;

   typedef logic [WORD_W-1:0]    word_type;
   typedef logic [KEY_IDX_W-1:0] key_idx_type;

   // key register indexes on the csr port
   localparam key_idx_type KEY_IDX_0 = 2'd0;
   localparam key_idx_type KEY_IDX_1 = 2'd1;
   localparam key_idx_type KEY_IDX_2 = 2'd2;
   localparam key_idx_type KEY_IDX_3 = 2'd3;

   // operation codes
   localparam logic FUNC_ENCRYPT = 1'b0;
   localparam logic FUNC_DECRYPT = 1'b1;

   localparam word_type TEA_DELTA = 32'h9e37_79b9;

   typedef struct packed {
      word_type k0;
      word_type k1;
      word_type k2;
      word_type k3;
   } key_set_type;

   typedef struct packed {
      logic     func;
      word_type left;
      word_type right;
   } blk_type;

   // delta times n, modulo 2^32; only called with elaboration constants
   function automatic word_type round_sum(input int unsigned n);
      logic [63:0] prod;
      prod = 64'(TEA_DELTA) * 64'(n);
      return prod[WORD_W-1:0];
   endfunction

   // one tea mix of a half with the running sum and two key words
   function automatic word_type mix_half(input word_type x, input word_type total,
                                         input word_type ka, input word_type kb);
      return ((x << 4) + ka) ^ (x + total) ^ ((x >> 5) + kb);
   endfunction

endpackage

/* design/tea_req_if.sv */
// tea_req_if, tea_rsp_if: valid/ready channels for blocks going in and out
// of the tea block cipher unit. Depends on tea_pkg.
interface tea_req_if;
   logic              valid;
   logic              ready;
   logic              func;
   tea_pkg::word_type block_left;
   tea_pkg::word_type block_right;

   modport source (output valid, func, block_left, block_right, input ready);
   modport sink   (input valid, func, block_left, block_right, output ready);
endinterface

interface tea_rsp_if;
   logic              valid;
   logic              ready;
   tea_pkg::word_type out_left;
   tea_pkg::word_type out_right;

   modport source (output valid, out_left, out_right, input ready);
   modport sink   (input valid, out_left, out_right, output ready);
endinterface

/* design/tea_block_cipher_unit.sv */
// tea_block_cipher_unit: top level of the tea block cipher pipeline.
// Depends on tea_pkg, tea_req_if, tea_rsp_if, tea_key_regs, tea_half_round.
//
// Encrypts or decrypts one 64-bit block per cycle while the result side does
// not stall, with the Tiny Encryption Algorithm under a 128-bit key held in
// four csr words. The rounds are unrolled into 2*ROUNDS register stages,
// one half-round each (one mix of shift, add and xor plus the add or
// subtract into the other half), so a new block can be taken in every
// cycle unless the pipeline is stalled. Every stage has its own valid bit
// and holds on a stall, so bubbles close up and nothing is dropped or
// repeated. All stages read the key registers directly: write keys only
// while no block is in flight.
module tea_block_cipher_unit #(
   parameter int unsigned ROUNDS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   tea_req_if.sink              req_ch,
   tea_rsp_if.source            rsp_ch,
   input  logic                 csr_wr_en,
   input  tea_pkg::key_idx_type csr_index,
   input  tea_pkg::word_type    csr_wdata
);

   localparam int unsigned STAGES = 2 * ROUNDS;

   tea_pkg::key_set_type keys;
   logic                 stg_valid [STAGES+1];
   logic                 stg_ready [STAGES+1];
   tea_pkg::blk_type     stg_blk   [STAGES+1];

   // key registers
   tea_key_regs u_keys (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .keys      (keys)
   );

   // input transaction into the first stage
   assign stg_valid[0]      = req_ch.valid;
   assign req_ch.ready      = stg_ready[0];
   assign stg_blk[0].func   = req_ch.func;
   assign stg_blk[0].left   = req_ch.block_left;
   assign stg_blk[0].right  = req_ch.block_right;

   // half-round stages; round r uses sum delta*(r+1) to encrypt and
   // delta*(ROUNDS-r) to decrypt
   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      localparam int unsigned RND = s / 2;
      tea_half_round #(
         .FIRST_HALF ((s % 2) == 0),
         .ENC_SUM    (tea_pkg::round_sum(RND + 1)),
         .DEC_SUM    (tea_pkg::round_sum(ROUNDS - RND))
      ) u_half (
         .clock     (clock),
         .reset     (reset),
         .keys      (keys),
         .in_valid  (stg_valid[s]),
         .in_ready  (stg_ready[s]),
         .in_blk    (stg_blk[s]),
         .out_valid (stg_valid[s+1]),
         .out_ready (stg_ready[s+1]),
         .out_blk   (stg_blk[s+1])
      );
   end

   // last stage register drives the result transaction
   assign rsp_ch.valid      = stg_valid[STAGES];
   assign stg_ready[STAGES] = rsp_ch.ready;
   assign rsp_ch.out_left   = stg_blk[STAGES].left;
   assign rsp_ch.out_right  = stg_blk[STAGES].right;

endmodule

/* design/tea_key_regs.sv */
// tea_key_regs: the four 32-bit key registers behind the csr write port.
// Depends on tea_pkg.
module tea_key_regs (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  tea_pkg::key_idx_type  csr_index,
   input  tea_pkg::word_type     csr_wdata,
   output tea_pkg::key_set_type  keys
);

   tea_pkg::key_set_type key_ff, key_in;

   // decode the register write
   always_comb begin
      key_in = key_ff;
      if (csr_wr_en) begin
         case (csr_index)
            tea_pkg::KEY_IDX_0: key_in.k0 = csr_wdata;
            tea_pkg::KEY_IDX_1: key_in.k1 = csr_wdata;
            tea_pkg::KEY_IDX_2: key_in.k2 = csr_wdata;
            tea_pkg::KEY_IDX_3: key_in.k3 = csr_wdata;
            default: key_in = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   assign keys = key_ff;

endmodule

/* design/tea_half_round.sv */
// tea_half_round: one register stage of the cipher pipeline that applies a
// single half-round (encrypt or decrypt) to the block. Depends on tea_pkg.
module tea_half_round #(
   parameter bit                FIRST_HALF = 1'b1,
   parameter tea_pkg::word_type ENC_SUM    = 32'h0,
   parameter tea_pkg::word_type DEC_SUM    = 32'h0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tea_pkg::key_set_type  keys,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  tea_pkg::blk_type      in_blk,
   output logic                  out_valid,
   input  logic                  out_ready,
   output tea_pkg::blk_type      out_blk
);

   logic              valid_ff, valid_in;
   tea_pkg::blk_type  blk_ff, blk_in;
   logic              upd_left;
   tea_pkg::word_type src, dst, total, ka, kb, mix, res;

   // encryption updates left then right; decryption right then left
   always_comb begin
      upd_left = (in_blk.func == tea_pkg::FUNC_DECRYPT) ? !FIRST_HALF : FIRST_HALF;
      src      = upd_left ? in_blk.right : in_blk.left;
      dst      = upd_left ? in_blk.left  : in_blk.right;
      ka       = upd_left ? keys.k0 : keys.k2;
      kb       = upd_left ? keys.k1 : keys.k3;
      total    = (in_blk.func == tea_pkg::FUNC_DECRYPT) ? DEC_SUM : ENC_SUM;
      mix      = tea_pkg::mix_half(src, total, ka, kb);
      res      = (in_blk.func == tea_pkg::FUNC_DECRYPT) ? dst - mix : dst + mix;
      blk_in   = in_blk;
      if (upd_left) begin
         blk_in.left = res;
      end else begin
         blk_in.right = res;
      end
   end

   // stage takes a new transaction when empty or when its content moves on
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         blk_ff <= blk_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_blk   = blk_ff;

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// testbench: self-checking bench for tea_block_cipher_unit, 64-bit tea blocks
// under csr-loaded keys, checked against an in-bench tea predictor.
// Depends on tea_pkg, tea_req_if, tea_rsp_if and tea_block_cipher_unit.
module testbench;
   import tea_pkg::*;

   localparam int unsigned CIPHER_ROUNDS  = 32;
   localparam int          PIPE_LATENCY   = 2 * CIPHER_ROUNDS;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          RANDOM_PHASES  = 8;
   localparam int          PHASE_BLOCKS   = 210;

   typedef struct packed {
      word_type left;
      word_type right;
   } tea_halves_type;

   typedef struct packed {
      logic           func;
      word_type       left;
      word_type       right;
      logic           typed;
      tea_halves_type typed_out;
   } block_row_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   key_idx_type csr_index;
   word_type csr_wdata;

   tea_req_if req_ch ();
   tea_rsp_if rsp_ch ();

   tea_block_cipher_unit #(.ROUNDS(CIPHER_ROUNDS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // key words as the block should currently hold them
   word_type key_word [KEY_COUNT];
   tea_halves_type expected_blocks [$];
   tea_halves_type want;

   int fail_count;
   int encrypt_count;
   int decrypt_count;
   int compared_count;
   int key_settings;
   int req_idle_pct;
   int rsp_stall_pct;
   int stall_cycles;
   int phase;
   int row;
   int set_idx;
   int blk;

   logic           last_func;
   tea_halves_type last_out;
   logic           pick_func;
   word_type       pick_left;
   word_type       pick_right;

   // directed blocks; the typed results hold for the all-zero key only
   block_row_type directed_rows [8] = '{
      '{FUNC_ENCRYPT, 32'h0000_0000, 32'h0000_0000, 1'b1, {32'h41ea_3a0a, 32'h94ba_a940}},
      '{FUNC_DECRYPT, 32'h41ea_3a0a, 32'h94ba_a940, 1'b1, {32'h0000_0000, 32'h0000_0000}},
      '{FUNC_ENCRYPT, 32'hffff_ffff, 32'hffff_ffff, 1'b0, '0},
      '{FUNC_DECRYPT, 32'hffff_ffff, 32'hffff_ffff, 1'b0, '0},
      '{FUNC_ENCRYPT, 32'h0000_0000, 32'hffff_ffff, 1'b0, '0},
      '{FUNC_DECRYPT, 32'hffff_ffff, 32'h0000_0000, 1'b0, '0},
      '{FUNC_ENCRYPT, 32'h8000_0000, 32'h0000_0001, 1'b0, '0},
      '{FUNC_DECRYPT, 32'h0000_0001, 32'h8000_0000, 1'b0, '0}
   };

   // key sets for the directed part; the first is the reset value, not written
   key_set_type directed_keys [3] = '{
      '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
      '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff},
      '{32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210}
   };

   // clock
   always #5 clock = ~clock;

   // one tea mix of a half with the running sum and two key words
   function automatic word_type tea_mix(word_type x, word_type total, word_type ka,
                                        word_type kb);
      return ((x << 4) + ka) ^ (x + total) ^ ((x >> 5) + kb);
   endfunction

   // full tea transform of one block under the current key words
   function automatic tea_halves_type tea_transform(logic func, word_type left,
                                                    word_type right);
      word_type       total;
      tea_halves_type res;
      if (func == FUNC_ENCRYPT) begin
         total = '0;
         for (int n = 0; n < CIPHER_ROUNDS; n++) begin
            total = total + TEA_DELTA;
            left  = left + tea_mix(right, total, key_word[0], key_word[1]);
            right = right + tea_mix(left, total, key_word[2], key_word[3]);
         end
      end else begin
         total = word_type'(TEA_DELTA * CIPHER_ROUNDS);
         for (int n = 0; n < CIPHER_ROUNDS; n++) begin
            right = right - tea_mix(left, total, key_word[2], key_word[3]);
            left  = left - tea_mix(right, total, key_word[0], key_word[1]);
            total = total - TEA_DELTA;
         end
      end
      res.left  = left;
      res.right = right;
      return res;
   endfunction

   // write all four key words, one per cycle
   task automatic load_key(input key_set_type keys);
      csr_wr_en <= 1'b1;
      csr_index <= KEY_IDX_0;
      csr_wdata <= keys.k0;
      @(posedge clock);
      csr_index <= KEY_IDX_1;
      csr_wdata <= keys.k1;
      @(posedge clock);
      csr_index <= KEY_IDX_2;
      csr_wdata <= keys.k2;
      @(posedge clock);
      csr_index <= KEY_IDX_3;
      csr_wdata <= keys.k3;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      key_word[0] = keys.k0;
      key_word[1] = keys.k1;
      key_word[2] = keys.k2;
      key_word[3] = keys.k3;
      key_settings++;
   endtask

   // offer one block, optionally after an idle burst, and record its result
   task automatic send_block(input logic func, input word_type left, input word_type right,
                             input logic typed, input tea_halves_type typed_out);
      int             gap;
      tea_halves_type prediction;
      gap = 0;
      if (req_idle_pct > 0 && $urandom_range(0, 99) < req_idle_pct)
         gap = $urandom_range(1, 18);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.func        <= func;
      req_ch.block_left  <= left;
      req_ch.block_right <= right;
      prediction = typed ? typed_out : tea_transform(func, left, right);
      do @(posedge clock); while (!req_ch.ready);
      expected_blocks.push_back(prediction);
      last_func = func;
      last_out  = prediction;
      if (func == FUNC_ENCRYPT)
         encrypt_count++;
      else
         decrypt_count++;
   endtask

   // hold off the sender until every outstanding result is back
   task automatic drain_pipeline();
      req_ch.valid <= 1'b0;
      while (expected_blocks.size() != 0) @(posedge clock);
   endtask

   // random half, biased now and then toward the extremes
   function automatic word_type pick_word();
      case ($urandom_range(0, 19))
         0: return 32'h0000_0000;
         1: return 32'hffff_ffff;
         2: return 32'h8000_0000;
         3: return 32'h0000_0001;
         default: return $urandom;
      endcase
   endfunction

   // result side: ready with random stall bursts
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_stall_pct > 0 && $urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
      end
   end

   // compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_blocks.size() == 0) begin
            $error("unexpected result: out_left %h out_right %h",
                   rsp_ch.out_left, rsp_ch.out_right);
            fail_count++;
         end else begin
            want = expected_blocks.pop_front();
            compared_count++;
            if (rsp_ch.out_left !== want.left) begin
               $error("out_left mismatch: expected %h, actual %h", want.left,
                      rsp_ch.out_left);
               fail_count++;
            end
            if (rsp_ch.out_right !== want.right) begin
               $error("out_right mismatch: expected %h, actual %h", want.right,
                      rsp_ch.out_right);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   initial begin
      stall_cycles = 0;
      while (stall_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   // stimulus
   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_index          = KEY_IDX_0;
      csr_wdata          = '0;
      req_ch.valid       = 1'b0;
      req_ch.func        = FUNC_ENCRYPT;
      req_ch.block_left  = '0;
      req_ch.block_right = '0;
      fail_count         = 0;
      encrypt_count      = 0;
      decrypt_count      = 0;
      compared_count     = 0;
      key_settings       = 1;
      req_idle_pct       = 20;
      rsp_stall_pct      = 20;
      last_func          = FUNC_ENCRYPT;
      last_out           = '0;
      for (int k = 0; k < KEY_COUNT; k++) key_word[k] = '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part: extreme blocks under zero, all-ones and mixed keys
      for (set_idx = 0; set_idx < 3; set_idx++) begin
         if (set_idx > 0) begin
            drain_pipeline();
            load_key(directed_keys[set_idx]);
         end
         for (row = 0; row < 8; row++)
            send_block(directed_rows[row].func, directed_rows[row].left,
                       directed_rows[row].right, directed_rows[row].typed && set_idx == 0,
                       directed_rows[row].typed_out);
      end

      // random part: fresh key per phase, mixed idling, round trips of recent blocks
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_pipeline();
         case (phase)
            0: load_key('{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
            1: load_key('{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
            default: load_key('{$urandom, $urandom, $urandom, $urandom});
         endcase
         if (phase == RANDOM_PHASES - 1) begin
            req_idle_pct  = 0;
            rsp_stall_pct = 0;
         end else begin
            req_idle_pct  = (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 10 : 40;
            rsp_stall_pct = (phase % 3 == 2) ? 0 : (phase % 3 == 0) ? 10 : 40;
         end
         for (blk = 0; blk < PHASE_BLOCKS; blk++) begin
            if ($urandom_range(0, 9) < 3) begin
               pick_func  = ~last_func;
               pick_left  = last_out.left;
               pick_right = last_out.right;
            end else begin
               pick_func  = 1'($urandom_range(0, 1));
               pick_left  = pick_word();
               pick_right = pick_word();
            end
            send_block(pick_func, pick_left, pick_right, 1'b0, '0);
         end
      end

      // wait for the pipeline to empty, then a little longer
      drain_pipeline();
      repeat (PIPE_LATENCY + 8) @(posedge clock);

      $display("run covered %0d encrypt and %0d decrypt blocks under %0d key settings,",
               encrypt_count, decrypt_count, key_settings);
      $display("%0d results compared, %0d mismatches", compared_count, fail_count);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
